[rtl/teaching_cpu_execute_unit_macros.svh]
// Assertion macros shared by the execute unit RTL.
// Used by cpuex_queue and cpuex_back; needs signals clk and rst_n in scope.
`ifndef TEACHING_CPU_EXECUTE_UNIT_MACROS_SVH
`define TEACHING_CPU_EXECUTE_UNIT_MACROS_SVH

`ifndef SYNTHESIS
`define CPUEX_ASSERT_IMP(lbl, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("cpuex assertion failed");
`define CPUEX_ASSERT_NXT(lbl, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("cpuex assertion failed");
`else
`define CPUEX_ASSERT_IMP(lbl, ante, cons)
`define CPUEX_ASSERT_NXT(lbl, ante, cons)
`endif

`endif

[rtl/cpuex_pkg.sv]
// Shared types and constants for the teaching CPU execute unit.
// No dependencies; imported by cpuex_front, cpuex_queue, cpuex_back and the top module.
`timescale 1ns / 1ps

package cpuex_pkg;

    localparam int IDX_W  = 4;
    localparam int DATA_W = 8;
    localparam int OP_W   = 4;

    localparam int REGISTER_COUNT_DEF = 16;
    localparam int QUEUE_DEPTH        = 2;

    localparam logic [OP_W-1:0] OP_LOAD     = 4'd0;
    localparam logic [OP_W-1:0] OP_LOAD_IMM = 4'd1;
    localparam logic [OP_W-1:0] OP_STORE    = 4'd2;
    localparam logic [OP_W-1:0] OP_MOVE     = 4'd3;
    localparam logic [OP_W-1:0] OP_ADD      = 4'd4;
    localparam logic [OP_W-1:0] OP_FADD     = 4'd5;
    localparam logic [OP_W-1:0] OP_OR       = 4'd6;
    localparam logic [OP_W-1:0] OP_AND      = 4'd7;
    localparam logic [OP_W-1:0] OP_XOR      = 4'd8;
    localparam logic [OP_W-1:0] OP_ROTATE   = 4'd9;
    localparam logic [OP_W-1:0] OP_JUMP     = 4'd10;
    localparam logic [OP_W-1:0] OP_HALT     = 4'd11;

    // Decoded instruction as it travels from the front to the back.
    typedef struct packed {
        logic [OP_W-1:0]   op;
        logic [IDX_W-1:0]  rd_a;
        logic [IDX_W-1:0]  rd_b;
        logic              wr_en;
        logic [IDX_W-1:0]  wr_idx;
        logic [DATA_W-1:0] imm;
        logic [DATA_W-1:0] mem_data;
    } dec_t;

endpackage

[rtl/cpuex_ram.sv]
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
`timescale 1ns / 1ps

module cpuex_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                           clk,
    input  logic                           wr_en,
    input  logic [$clog2(DEPTH)-1:0]       wr_addr,
    input  logic [WIDTH-1:0]               wr_data,
    input  logic [$clog2(DEPTH)-1:0]       rd_addr,
    output logic [WIDTH-1:0]               rd_data
);

    logic [WIDTH-1:0] mem_reg [DEPTH];

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem_reg[wr_addr] <= wr_data;
        end
        rd_data <= mem_reg[rd_addr];
    end

endmodule

[rtl/cpuex_front.sv]
// Front end: takes instruction transfers and classifies them into read
// ports and write target. Depends on cpuex_pkg.
`timescale 1ns / 1ps

module cpuex_front (
    input  logic                       in_valid,
    output logic                       in_stall,
    input  logic [3:0]                 opcode,
    input  logic [3:0]                 reg_r,
    input  logic [3:0]                 reg_s,
    input  logic [3:0]                 reg_t,
    input  logic [7:0]                 immediate,
    input  logic [7:0]                 mem_data,
    input  logic                       q_full,
    output logic                       q_push,
    output cpuex_pkg::dec_t            q_data
);
    import cpuex_pkg::*;

    assign in_stall = q_full;
    assign q_push   = in_valid && !q_full;

    always_comb
    begin
        q_data          = '0;
        q_data.op       = opcode;
        q_data.imm      = immediate;
        q_data.mem_data = mem_data;
        unique case (opcode)
            OP_LOAD, OP_LOAD_IMM:
            begin
                q_data.wr_en  = 1'b1;
                q_data.wr_idx = reg_r;
            end
            OP_STORE:
            begin
                q_data.rd_a = reg_r;
            end
            OP_MOVE:
            begin
                q_data.rd_a   = reg_r;
                q_data.wr_en  = 1'b1;
                q_data.wr_idx = reg_s;
            end
            OP_ADD, OP_FADD, OP_OR, OP_AND, OP_XOR:
            begin
                q_data.rd_a   = reg_s;
                q_data.rd_b   = reg_t;
                q_data.wr_en  = 1'b1;
                q_data.wr_idx = reg_r;
            end
            OP_ROTATE:
            begin
                q_data.rd_a   = reg_r;
                q_data.wr_en  = 1'b1;
                q_data.wr_idx = reg_r;
            end
            OP_JUMP:
            begin
                // compare against R0
                q_data.rd_a = reg_r;
                q_data.rd_b = '0;
            end
            default:
            begin
                // halt and unused codes touch no register
            end
        endcase
    end

endmodule

[rtl/cpuex_queue.sv]
// Short FIFO of decoded instructions between front and back.
// Depends on cpuex_pkg and the assertion macro header.
`timescale 1ns / 1ps
`include "teaching_cpu_execute_unit_macros.svh"

module cpuex_queue (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             push,
    input  cpuex_pkg::dec_t  push_data,
    input  logic             pop,
    output cpuex_pkg::dec_t  head,
    output logic             full,
    output logic             empty
);
    import cpuex_pkg::*;

    localparam int PW = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
    localparam int CW = $clog2(QUEUE_DEPTH + 1);
    localparam logic [CW-1:0] DEPTH_C = CW'(QUEUE_DEPTH);
    localparam logic [PW-1:0] LAST_P  = PW'(QUEUE_DEPTH - 1);

    dec_t          entries_reg [QUEUE_DEPTH];
    logic [PW-1:0] wptr_reg, wptr_next;
    logic [PW-1:0] rptr_reg, rptr_next;
    logic [CW-1:0] count_reg, count_next;

    assign full  = (count_reg == DEPTH_C);
    assign empty = (count_reg == '0);
    assign head  = entries_reg[rptr_reg];

    always_comb
    begin
        wptr_next  = wptr_reg;
        rptr_next  = rptr_reg;
        count_next = count_reg;
        if (push)
        begin
            wptr_next = (wptr_reg == LAST_P) ? '0 : wptr_reg + 1'b1;
        end
        if (pop)
        begin
            rptr_next = (rptr_reg == LAST_P) ? '0 : rptr_reg + 1'b1;
        end
        if (push && !pop)
        begin
            count_next = count_reg + 1'b1;
        end
        else if (pop && !push)
        begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wptr_reg  <= '0;
            rptr_reg  <= '0;
            count_reg <= '0;
        end
        else
        begin
            wptr_reg  <= wptr_next;
            rptr_reg  <= rptr_next;
            count_reg <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            entries_reg[wptr_reg] <= push_data;
        end
    end

    `CPUEX_ASSERT_IMP(a_q_no_overflow, push, !full)
    `CPUEX_ASSERT_IMP(a_q_no_underflow, pop, !empty)
    `CPUEX_ASSERT_NXT(a_q_push_lands, push && !pop, !empty)

endmodule

[rtl/cpuex_back.sv]
// Back end: register file, execution of one decoded instruction and the
// result register. Depends on cpuex_pkg, cpuex_ram and the macro header.
`timescale 1ns / 1ps
`include "teaching_cpu_execute_unit_macros.svh"

module cpuex_back #(
    parameter int REGISTER_COUNT = cpuex_pkg::REGISTER_COUNT_DEF
) (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             q_empty,
    input  cpuex_pkg::dec_t  q_head,
    output logic             q_pop,
    output logic             out_valid,
    input  logic             out_stall,
    output logic             reg_write,
    output logic [3:0]       reg_index,
    output logic [7:0]       reg_value,
    output logic             mem_write,
    output logic [7:0]       mem_address,
    output logic [7:0]       mem_value,
    output logic             jump_taken,
    output logic [7:0]       jump_target,
    output logic             halt
);
    import cpuex_pkg::*;

    localparam int AW = $clog2(REGISTER_COUNT);
    localparam logic [IDX_W:0] REG_LIMIT = (IDX_W + 1)'(REGISTER_COUNT);

    localparam logic S_IDLE = 1'b0;
    localparam logic S_EXEC = 1'b1;

    function automatic logic in_range(input logic [IDX_W-1:0] idx);
        return ({1'b0, idx} < REG_LIMIT);
    endfunction

    // sign, excess-4 exponent, 4-bit magnitude
    function automatic logic [7:0] fp_add(input logic [7:0] a, input logic [7:0] b);
        logic [2:0] ea;
        logic [2:0] eb;
        logic [3:0] ma;
        logic [3:0] mb;
        logic [3:0] e;
        logic [5:0] sa;
        logic [5:0] sb;
        logic [5:0] sum;
        logic [5:0] mag;
        logic       neg;
        ea = a[6:4];
        eb = b[6:4];
        ma = a[3:0];
        mb = b[3:0];
        if (ea < eb)
        begin
            ma = ma >> (eb - ea);
            e  = {1'b0, eb};
        end
        else
        begin
            mb = mb >> (ea - eb);
            e  = {1'b0, ea};
        end
        sa  = a[7] ? (6'd0 - {2'b00, ma}) : {2'b00, ma};
        sb  = b[7] ? (6'd0 - {2'b00, mb}) : {2'b00, mb};
        sum = sa + sb;
        neg = sum[5];
        mag = neg ? (6'd0 - sum) : sum;
        if (mag > 6'd15)
        begin
            mag = mag >> 1;
            e   = e + 4'd1;
        end
        if (e > 4'd7)
        begin
            mag = 6'd15;
            e   = 4'd7;
        end
        return {neg, e[2:0], mag[3:0]};
    endfunction

    logic                      state_reg, state_next;
    dec_t                      cur_reg;
    logic                      a_ok_reg, a_ok_next;
    logic                      b_ok_reg, b_ok_next;
    logic [REGISTER_COUNT-1:0] written_reg, written_next;
    logic [DATA_W-1:0]         ram_a_q;
    logic [DATA_W-1:0]         ram_b_q;
    logic [DATA_W-1:0]         op_a;
    logic [DATA_W-1:0]         op_b;
    logic [2*DATA_W-1:0]       rot_w;
    logic                      exec;
    logic                      rf_we;
    logic [DATA_W-1:0]         res_val;
    logic                      res_mem;
    logic                      res_jump;
    logic                      res_halt;
    logic                      out_valid_reg, out_valid_next;
    logic                      reg_write_reg;
    logic [IDX_W-1:0]          reg_index_reg;
    logic [DATA_W-1:0]         reg_value_reg;
    logic                      mem_write_reg;
    logic [DATA_W-1:0]         mem_address_reg;
    logic [DATA_W-1:0]         mem_value_reg;
    logic                      jump_taken_reg;
    logic [DATA_W-1:0]         jump_target_reg;
    logic                      halt_reg;

    // pop the queue head only while idle and the output can take a result; execute in the next cycle
    assign exec  = (state_reg == S_EXEC);
    assign q_pop = (state_reg == S_IDLE) && !q_empty && (!out_valid_reg || !out_stall);
    assign rf_we = exec && cur_reg.wr_en && in_range(cur_reg.wr_idx);

    // two copies of the register file give two read ports
    cpuex_ram #(
        .WIDTH (DATA_W),
        .DEPTH (REGISTER_COUNT)
    ) u_rf_a (
        .clk     (clk),
        .wr_en   (rf_we),
        .wr_addr (cur_reg.wr_idx[AW-1:0]),
        .wr_data (res_val),
        .rd_addr (q_head.rd_a[AW-1:0]),
        .rd_data (ram_a_q)
    );

    cpuex_ram #(
        .WIDTH (DATA_W),
        .DEPTH (REGISTER_COUNT)
    ) u_rf_b (
        .clk     (clk),
        .wr_en   (rf_we),
        .wr_addr (cur_reg.wr_idx[AW-1:0]),
        .wr_data (res_val),
        .rd_addr (q_head.rd_b[AW-1:0]),
        .rd_data (ram_b_q)
    );

    // registers never written since reset read as zero
    always_comb
    begin
        state_next   = state_reg;
        a_ok_next    = a_ok_reg;
        b_ok_next    = b_ok_reg;
        written_next = written_reg;
        if (q_pop)
        begin
            state_next = S_EXEC;
            a_ok_next  = in_range(q_head.rd_a) && written_reg[q_head.rd_a[AW-1:0]];
            b_ok_next  = in_range(q_head.rd_b) && written_reg[q_head.rd_b[AW-1:0]];
        end
        else if (exec)
        begin
            state_next = S_IDLE;
        end
        if (rf_we)
        begin
            written_next[cur_reg.wr_idx[AW-1:0]] = 1'b1;
        end
    end

    assign op_a  = a_ok_reg ? ram_a_q : '0;
    assign op_b  = b_ok_reg ? ram_b_q : '0;
    assign rot_w = {op_a, op_a} >> cur_reg.imm[2:0];

    always_comb
    begin
        res_val  = '0;
        res_mem  = 1'b0;
        res_jump = 1'b0;
        res_halt = 1'b0;
        unique case (cur_reg.op)
            OP_LOAD:     res_val = cur_reg.mem_data;
            OP_LOAD_IMM: res_val = cur_reg.imm;
            OP_STORE:    res_mem = 1'b1;
            OP_MOVE:     res_val = op_a;
            OP_ADD:      res_val = op_a + op_b;
            OP_FADD:     res_val = fp_add(op_a, op_b);
            OP_OR:       res_val = op_a | op_b;
            OP_AND:      res_val = op_a & op_b;
            OP_XOR:      res_val = op_a ^ op_b;
            OP_ROTATE:   res_val = rot_w[DATA_W-1:0];
            OP_JUMP:     res_jump = (op_a == op_b);
            OP_HALT:     res_halt = 1'b1;
            default:     res_val = '0;
        endcase
    end

    always_comb
    begin
        out_valid_next = out_valid_reg;
        if (exec)
        begin
            out_valid_next = 1'b1;
        end
        else if (out_valid_reg && !out_stall)
        begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            a_ok_reg      <= 1'b0;
            b_ok_reg      <= 1'b0;
            written_reg   <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            a_ok_reg      <= a_ok_next;
            b_ok_reg      <= b_ok_next;
            written_reg   <= written_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (q_pop)
        begin
            cur_reg <= q_head;
        end
        if (exec)
        begin
            reg_write_reg   <= rf_we;
            reg_index_reg   <= rf_we ? cur_reg.wr_idx : '0;
            reg_value_reg   <= rf_we ? res_val : '0;
            mem_write_reg   <= res_mem;
            mem_address_reg <= res_mem ? cur_reg.imm : '0;
            mem_value_reg   <= res_mem ? op_a : '0;
            jump_taken_reg  <= res_jump;
            jump_target_reg <= res_jump ? cur_reg.imm : '0;
            halt_reg        <= res_halt;
        end
    end

    assign out_valid   = out_valid_reg;
    assign reg_write   = reg_write_reg;
    assign reg_index   = reg_index_reg;
    assign reg_value   = reg_value_reg;
    assign mem_write   = mem_write_reg;
    assign mem_address = mem_address_reg;
    assign mem_value   = mem_value_reg;
    assign jump_taken  = jump_taken_reg;
    assign jump_target = jump_target_reg;
    assign halt        = halt_reg;

    `CPUEX_ASSERT_IMP(a_exec_out_free, exec, !out_valid_reg)
    `CPUEX_ASSERT_IMP(a_one_effect, out_valid_reg,
        $onehot0({reg_write_reg, mem_write_reg, jump_taken_reg, halt_reg}))
    `CPUEX_ASSERT_IMP(a_write_in_range, out_valid_reg && reg_write_reg,
        ({1'b0, reg_index_reg} < REG_LIMIT))
    `CPUEX_ASSERT_NXT(a_pop_then_exec, q_pop, state_reg == S_EXEC)

endmodule

[rtl/teaching_cpu_execute_unit.sv]
// Execute unit of an 8-bit teaching processor: front decode, queue, back end.
// Depends on cpuex_pkg, cpuex_front, cpuex_queue, cpuex_back, cpuex_ram.
//
// One instruction transfer in, exactly one result transfer out, in order.
// The front classifies each instruction and parks it in a two-entry queue;
// the back end reads the register file (registered read, two copies for
// two read ports), then executes and writes back in the following cycle.
// The back end takes the next instruction only after the last one has executed,
// and an instruction passes through a queue entry, the register file read and
// the result registers before its result can transfer out. The
// register file clears through per-register written bits, so the unit takes
// instructions from the first cycle after reset.
`timescale 1ns / 1ps

module teaching_cpu_execute_unit #(
    parameter int REGISTER_COUNT = cpuex_pkg::REGISTER_COUNT_DEF
) (
    input  logic       clk,
    input  logic       rst_n,
    input  logic       in_valid,
    output logic       in_stall,
    input  logic [3:0] opcode,
    input  logic [3:0] reg_r,
    input  logic [3:0] reg_s,
    input  logic [3:0] reg_t,
    input  logic [7:0] immediate,
    input  logic [7:0] mem_data,
    output logic       out_valid,
    input  logic       out_stall,
    output logic       reg_write,
    output logic [3:0] reg_index,
    output logic [7:0] reg_value,
    output logic       mem_write,
    output logic [7:0] mem_address,
    output logic [7:0] mem_value,
    output logic       jump_taken,
    output logic [7:0] jump_target,
    output logic       halt
);
    import cpuex_pkg::*;

    dec_t q_in;
    dec_t q_head;
    logic q_push;
    logic q_pop;
    logic q_full;
    logic q_empty;

    cpuex_front u_front (
        .in_valid  (in_valid),
        .in_stall  (in_stall),
        .opcode    (opcode),
        .reg_r     (reg_r),
        .reg_s     (reg_s),
        .reg_t     (reg_t),
        .immediate (immediate),
        .mem_data  (mem_data),
        .q_full    (q_full),
        .q_push    (q_push),
        .q_data    (q_in)
    );

    cpuex_queue u_queue (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (q_push),
        .push_data (q_in),
        .pop       (q_pop),
        .head      (q_head),
        .full      (q_full),
        .empty     (q_empty)
    );

    cpuex_back #(
        .REGISTER_COUNT (REGISTER_COUNT)
    ) u_back (
        .clk         (clk),
        .rst_n       (rst_n),
        .q_empty     (q_empty),
        .q_head      (q_head),
        .q_pop       (q_pop),
        .out_valid   (out_valid),
        .out_stall   (out_stall),
        .reg_write   (reg_write),
        .reg_index   (reg_index),
        .reg_value   (reg_value),
        .mem_write   (mem_write),
        .mem_address (mem_address),
        .mem_value   (mem_value),
        .jump_taken  (jump_taken),
        .jump_target (jump_target),
        .halt        (halt)
    );

endmodule
